[rtl/ncf_pkg.sv]
package ncf_pkg;

   // fixed field widths
   localparam int FUNC_W     = 2;
   localparam int NODE_W     = 4;
   localparam int WEIGHT_W   = 32;
   localparam int DIST_W     = 40;
   localparam int KIND_W     = 3;
   localparam int CNT_W      = 5;
   localparam int EPS_W      = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam int EDGE_W     = 2 * NODE_W + WEIGHT_W;
   localparam int NODE_SLOTS = 2 ** NODE_W;

   localparam int DEF_MAX_NODES = 16;
   localparam int DEF_MAX_EDGES = 256;

   localparam logic [EPS_W-1:0] EPSILON_RESET = EPS_W'(17);

   // request codes
   localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON    = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_STORED  = 3'd0,
      KIND_FULL    = 3'd1,
      KIND_NODE    = 3'd2,
      KIND_NONE    = 3'd3,
      KIND_CLEARED = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_FETCH,
      ST_DECODE,
      ST_EVAL,
      ST_WALK,
      ST_CYC_INIT,
      ST_CYCLE,
      ST_EMIT_X,
      ST_EMIT_BUF
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic              edge_wr;
      logic              fetch;
      logic              dist_rd;
      logic              eval;
      logic              init;
      logic              walk_step;
      logic              cyc_start;
      logic              cyc_step;
      logic [CNT_W-1:0]  n;
      logic [NODE_W-1:0] buf_idx;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic              relaxed;
      logic              x_valid;
      logic              cur_valid;
      logic              next_is_x;
      logic [NODE_W-1:0] x_node;
      logic [NODE_W-1:0] buf_node;
   } sts_type;

endpackage

[rtl/ncf_datapath.sv]
module ncf_datapath import ncf_pkg::*; #(
   parameter  int MAX_EDGES = DEF_MAX_EDGES,
   localparam int EA_W      = $clog2(MAX_EDGES)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [NODE_W-1:0]     req_from_node,
   input  logic [NODE_W-1:0]     req_to_node,
   input  logic [WEIGHT_W-1:0]   req_weight,
   input  logic [EA_W-1:0]       edge_addr,
   input  cmd_type               cmd,
   output sts_type               sts
);

   logic [EDGE_W-1:0] edge_mem_ff [MAX_EDGES];
   logic [EDGE_W-1:0] edge_q_ff;
   logic [DIST_W-1:0] dist_mem_ff [NODE_SLOTS];
   logic [DIST_W-1:0] dsrc_ff, ddst_ff;
   logic [NODE_SLOTS-1:0] known_ff, known_in;
   logic [NODE_SLOTS-1:0] pvalid_ff, pvalid_in;
   logic [NODE_W-1:0] pred_ff [NODE_SLOTS];
   logic [NODE_W-1:0] buf_ff [NODE_SLOTS];
   logic [NODE_W-1:0] x_ff, cur_ff;
   logic [EPS_W-1:0]  epsilon_ff;

   logic [NODE_W-1:0]       src, dst;
   logic [WEIGHT_W-1:0]     wt;
   logic signed [DIST_W:0]  sum_w, thr_w;
   logic [DIST_W-1:0]       cand;
   logic                    in_range, lt, relax, relax_en;

   assign src = edge_q_ff[EDGE_W-1 -: NODE_W];
   assign dst = edge_q_ff[WEIGHT_W +: NODE_W];
   assign wt  = edge_q_ff[WEIGHT_W-1:0];

   // epsilon register
   always_ff @(posedge clock) begin
      if (reset) begin
         epsilon_ff <= EPSILON_RESET;
      end else if (csr_we && csr_index == CSR_EPSILON) begin
         epsilon_ff <= csr_wdata[EPS_W-1:0];
      end
   end

   // edge store: one write, one registered read
   always_ff @(posedge clock) begin
      if (cmd.edge_wr) begin
         edge_mem_ff[edge_addr] <= {req_from_node, req_to_node, req_weight};
      end
      if (cmd.fetch) begin
         edge_q_ff <= edge_mem_ff[edge_addr];
      end
   end

   // relaxation: saturating add, then compare against threshold
   always_comb begin
      sum_w = $signed({dsrc_ff[DIST_W-1], dsrc_ff})
            + $signed({{(DIST_W+1-WEIGHT_W){wt[WEIGHT_W-1]}}, wt});
      if (sum_w[DIST_W] != sum_w[DIST_W-1]) begin
         cand = sum_w[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
      end else begin
         cand = sum_w[DIST_W-1:0];
      end
      thr_w = $signed({ddst_ff[DIST_W-1], ddst_ff})
            - $signed({{(DIST_W+1-EPS_W){1'b0}}, epsilon_ff});
      lt       = $signed({cand[DIST_W-1], cand}) < thr_w;
      in_range = ({1'b0, src} < cmd.n) && ({1'b0, dst} < cmd.n);
      relax    = in_range && known_ff[src] && (!known_ff[dst] || lt);
      relax_en = cmd.eval && relax;
   end

   // distance store: two registered reads, one write
   always_ff @(posedge clock) begin
      if (cmd.init) begin
         dist_mem_ff[0] <= '0;
      end else if (relax_en) begin
         dist_mem_ff[dst] <= cand;
      end
      if (cmd.dist_rd) begin
         dsrc_ff <= dist_mem_ff[src];
         ddst_ff <= dist_mem_ff[dst];
      end
   end

   // known and predecessor valid bits
   always_comb begin
      known_in  = known_ff;
      pvalid_in = pvalid_ff;
      if (cmd.init) begin
         known_in  = NODE_SLOTS'(1);
         pvalid_in = '0;
      end else if (relax_en) begin
         known_in[dst]  = 1'b1;
         pvalid_in[dst] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff  <= '0;
         pvalid_ff <= '0;
      end else begin
         known_ff  <= known_in;
         pvalid_ff <= pvalid_in;
      end
   end

   // predecessors, walk pointers and cycle buffer
   always_ff @(posedge clock) begin
      if (relax_en) begin
         pred_ff[dst] <= src;
         x_ff         <= dst;
      end else if (cmd.walk_step) begin
         x_ff <= pred_ff[x_ff];
      end
      if (cmd.cyc_start) begin
         cur_ff <= x_ff;
      end else if (cmd.cyc_step) begin
         buf_ff[cmd.buf_idx] <= cur_ff;
         cur_ff              <= pred_ff[cur_ff];
      end
   end

   assign sts.relaxed   = relax;
   assign sts.x_valid   = pvalid_ff[x_ff];
   assign sts.cur_valid = pvalid_ff[cur_ff];
   assign sts.next_is_x = pred_ff[cur_ff] == x_ff;
   assign sts.x_node    = x_ff;
   assign sts.buf_node  = buf_ff[cmd.buf_idx];

endmodule

[rtl/ncf_controller.sv]
module ncf_controller import ncf_pkg::*; #(
   parameter  int MAX_EDGES = DEF_MAX_EDGES,
   localparam int EA_W      = $clog2(MAX_EDGES)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [FUNC_W-1:0]     req_func,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic [EA_W-1:0]       edge_addr,
   output cmd_type               cmd,
   input  sts_type               sts,
   output logic                  rsp_strobe,
   output logic [KIND_W-1:0]     rsp_kind,
   output logic [NODE_W-1:0]     rsp_node,
   output logic                  rsp_last
);

   localparam int TOT_W = $clog2(MAX_EDGES + 1);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  node_count_ff;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [EA_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]  n_ff, n_in, pass_ff, pass_in, step_ff, step_in, len_ff, len_in;
   logic [CNT_W-1:0]  n_clamp, lim;
   logic              detect, more_edges;
   logic              rsp_strobe_ff, rsp_strobe_in, rsp_last_ff, rsp_last_in;
   kind_type          rsp_kind_ff, rsp_kind_in;
   logic [NODE_W-1:0] rsp_node_ff, rsp_node_in;

   // node count register
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= '0;
      end else if (csr_we && csr_index == CSR_NODE_COUNT) begin
         node_count_ff <= csr_wdata[CNT_W-1:0];
      end
   end

   assign n_clamp    = (int'(node_count_ff) > DEF_MAX_NODES) ? CNT_W'(DEF_MAX_NODES)
                                                              : node_count_ff;
   assign lim        = (n_ff > CNT_W'(NODE_SLOTS)) ? CNT_W'(NODE_SLOTS) : n_ff;
   assign detect     = pass_ff == n_ff - CNT_W'(1);
   assign more_edges = (TOT_W'(idx_ff) + TOT_W'(1)) < total_ff;

   // next state, commands and result word
   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      idx_in        = idx_ff;
      n_in          = n_ff;
      pass_in       = pass_ff;
      step_in       = step_ff;
      len_in        = len_ff;
      edge_addr     = idx_ff;
      cmd           = '0;
      cmd.n         = n_ff;
      rsp_strobe_in = 1'b0;
      rsp_kind_in   = KIND_NONE;
      rsp_node_in   = '0;
      rsp_last_in   = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_func)
                  FUNC_LOAD: begin
                     rsp_strobe_in = 1'b1;
                     if (total_ff == TOT_W'(MAX_EDGES)) begin
                        rsp_kind_in = KIND_FULL;
                     end else begin
                        cmd.edge_wr = 1'b1;
                        edge_addr   = total_ff[EA_W-1:0];
                        total_in    = total_ff + TOT_W'(1);
                        rsp_kind_in = KIND_STORED;
                     end
                  end
                  FUNC_SEARCH: begin
                     n_in = n_clamp;
                     if (n_clamp == '0) begin
                        rsp_strobe_in = 1'b1;
                     end else begin
                        state_in = ST_INIT;
                     end
                  end
                  FUNC_CLEAR: begin
                     total_in      = '0;
                     rsp_strobe_in = 1'b1;
                     rsp_kind_in   = KIND_CLEARED;
                  end
                  default: ;
               endcase
            end
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            pass_in  = '0;
            idx_in   = '0;
            if (total_ff == '0) begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_DECODE;
         end
         ST_DECODE: begin
            cmd.dist_rd = 1'b1;
            state_in    = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (detect && sts.relaxed) begin
               step_in  = '0;
               state_in = ST_WALK;
            end else if (more_edges) begin
               idx_in   = idx_ff + EA_W'(1);
               state_in = ST_FETCH;
            end else if (detect) begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               pass_in  = pass_ff + CNT_W'(1);
               idx_in   = '0;
               state_in = ST_FETCH;
            end
         end
         // step back node count times to land on the cycle
         ST_WALK: begin
            if (!sts.x_valid) begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.walk_step = 1'b1;
               step_in       = step_ff + CNT_W'(1);
               if (step_ff + CNT_W'(1) == n_ff) begin
                  state_in = ST_CYC_INIT;
               end
            end
         end
         ST_CYC_INIT: begin
            cmd.cyc_start = 1'b1;
            len_in        = '0;
            state_in      = ST_CYCLE;
         end
         // collect the cycle, newest predecessor last
         ST_CYCLE: begin
            if (len_ff >= lim || !sts.cur_valid) begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.cyc_step = 1'b1;
               cmd.buf_idx  = len_ff[NODE_W-1:0];
               len_in       = len_ff + CNT_W'(1);
               if (sts.next_is_x) begin
                  state_in = ST_EMIT_X;
               end
            end
         end
         ST_EMIT_X: begin
            rsp_strobe_in = 1'b1;
            rsp_kind_in   = KIND_NODE;
            rsp_node_in   = sts.x_node;
            rsp_last_in   = 1'b0;
            state_in      = ST_EMIT_BUF;
         end
         // play the buffer back in trading order
         ST_EMIT_BUF: begin
            cmd.buf_idx   = NODE_W'(len_ff - CNT_W'(1));
            rsp_strobe_in = 1'b1;
            rsp_kind_in   = KIND_NODE;
            rsp_node_in   = sts.buf_node;
            rsp_last_in   = len_ff == CNT_W'(1);
            len_in        = len_ff - CNT_W'(1);
            if (len_ff == CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         total_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         total_ff      <= total_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      n_ff        <= n_in;
      pass_ff     <= pass_in;
      step_ff     <= step_in;
      len_ff      <= len_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_node_ff <= rsp_node_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_kind   = rsp_kind_ff;
   assign rsp_node   = rsp_node_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

[rtl/negative_cycle_finder.sv]
// Bellman-Ford negative cycle finder. A command is taken when start is high and busy is low.
// Loads (edge stored or store full) and clears answer with one result word on the next cycle
// and leave busy low, so a load can be issued every cycle. A search holds busy high while
// the edge list is swept up to n times for n nodes, each edge going through an edge store
// read, a distance store read, then relax and write back, and then while it walks back,
// collects the cycle and plays it back. Result words are shown for exactly one cycle with
// rsp_strobe high and cannot be held off; a found cycle comes out one node per cycle, start
// node first and repeated last, with rsp_last on the final word. Registers are written
// through csr_we at any time the block is idle.
module negative_cycle_finder import ncf_pkg::*; #(
   parameter int MAX_EDGES = DEF_MAX_EDGES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [FUNC_W-1:0]     req_func,
   input  logic [NODE_W-1:0]     req_from_node,
   input  logic [NODE_W-1:0]     req_to_node,
   input  logic [WEIGHT_W-1:0]   req_weight,
   output logic                  rsp_strobe,
   output logic [KIND_W-1:0]     rsp_kind,
   output logic [NODE_W-1:0]     rsp_node,
   output logic                  rsp_last,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int EA_W = $clog2(MAX_EDGES);

   cmd_type         cmd;
   sts_type         sts;
   logic [EA_W-1:0] edge_addr;

   ncf_controller #(
      .MAX_EDGES (MAX_EDGES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_func   (req_func),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .edge_addr  (edge_addr),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_kind   (rsp_kind),
      .rsp_node   (rsp_node),
      .rsp_last   (rsp_last)
   );

   ncf_datapath #(
      .MAX_EDGES (MAX_EDGES)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_from_node (req_from_node),
      .req_to_node   (req_to_node),
      .req_weight    (req_weight),
      .edge_addr     (edge_addr),
      .cmd           (cmd),
      .sts           (sts)
   );

`ifndef SYNTH
   // only cycle node words may continue
   a_last_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_kind != KIND_NODE |-> rsp_last)
      else $error("non-node result without last");

   a_node_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_kind != KIND_NODE |-> rsp_node == '0)
      else $error("node field set on non-node result");

   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a command");
`endif

endmodule
